FILE: rtl/kiwd_pkg.sv
package kiwd_pkg;

    localparam int DataW   = 16;
    localparam int CountW  = 12;
    localparam int PreselW = 3;
    localparam int PrecntW = 8;

    // item modes
    localparam logic [1:0] MODE_READ  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_TICK  = 2'd2;

    // register indexes
    localparam logic [2:0] REG_KEY    = 3'd0;
    localparam logic [2:0] REG_PRESC  = 3'd1;
    localparam logic [2:0] REG_RELOAD = 3'd2;
    localparam logic [2:0] REG_STATUS = 3'd3;
    localparam logic [2:0] REG_WINDOW = 3'd4;

    localparam logic [DataW-1:0]  KEY_START  = 16'hCCCC;
    localparam logic [DataW-1:0]  KEY_RELOAD = 16'hAAAA;
    localparam logic [DataW-1:0]  KEY_UNLOCK = 16'h5555;
    localparam logic [CountW-1:0] COUNT_MAX  = 12'hFFF;

    typedef struct packed {
        logic [1:0]       mode;
        logic [2:0]       reg_index;
        logic [DataW-1:0] write_data;
    } t_in_item;

    typedef struct packed {
        logic [DataW-1:0] read_data;
        logic             reset_request;
        logic             write_refused;
    } t_out_item;

    // prescale divisor: 4 << sel, capped at 256
    function automatic logic [PrecntW:0] prescale_div(input logic [PreselW-1:0] sel);
        logic [PrecntW:0] d;
        d = 9'd256;
        case (sel)
            3'd0:    d = 9'd4;
            3'd1:    d = 9'd8;
            3'd2:    d = 9'd16;
            3'd3:    d = 9'd32;
            3'd4:    d = 9'd64;
            3'd5:    d = 9'd128;
            default: d = 9'd256;
        endcase
        return d;
    endfunction

endpackage

FILE: rtl/kiwd_ifs.sv
interface kiwd_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [2:0]  reg_index;
    logic [15:0] write_data;

    modport source (output valid, output mode, output reg_index, output write_data,
                    input ready);
    modport sink (input valid, input mode, input reg_index, input write_data,
                  output ready);
endinterface

interface kiwd_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] read_data;
    logic        reset_request;
    logic        write_refused;

    modport source (output valid, output read_data, output reset_request,
                    output write_refused, input ready);
    modport sink (input valid, input read_data, input reset_request,
                  input write_refused, output ready);
endinterface

interface kiwd_cfg_if;
    logic valid;
    logic ready;
    logic data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/kiwd_core.sv
module kiwd_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_data,
    input  logic                i_step,
    input  kiwd_pkg::t_in_item  i_item,
    output kiwd_pkg::t_out_item o_res
);
    import kiwd_pkg::*;

    logic               r_has_window;
    logic [DataW-1:0]   r_last_key,   n_last_key;
    logic [PreselW-1:0] r_presel,     n_presel;
    logic [CountW-1:0]  r_reload,     n_reload;
    logic [CountW-1:0]  r_window,     n_window;
    logic               r_running,    n_running;
    logic [PrecntW-1:0] r_precnt,     n_precnt;
    logic [CountW-1:0]  r_down,       n_down;

    logic               unlocked;
    logic               restart;
    logic [PrecntW:0]   precnt_inc;
    logic [CountW-1:0]  down_dec;
    t_out_item          res;

    assign unlocked   = (r_last_key == KEY_UNLOCK);
    assign precnt_inc = {1'b0, r_precnt} + 9'd1;
    assign down_dec   = r_down - 12'd1;

    always_comb begin
        n_last_key = r_last_key;
        n_presel   = r_presel;
        n_reload   = r_reload;
        n_window   = r_window;
        n_running  = r_running;
        n_precnt   = r_precnt;
        n_down     = r_down;
        restart    = 1'b0;
        res        = '0;

        case (i_item.mode)
            MODE_READ: begin
                case (i_item.reg_index)
                    REG_PRESC:  res.read_data = {{(DataW-PreselW){1'b0}}, r_presel};
                    REG_RELOAD: res.read_data = {{(DataW-CountW){1'b0}}, r_reload};
                    REG_WINDOW: begin
                        if (r_has_window) begin
                            res.read_data = {{(DataW-CountW){1'b0}}, r_window};
                        end
                    end
                    default: res.read_data = '0;
                endcase
            end
            MODE_WRITE: begin
                case (i_item.reg_index) inside
                    REG_KEY: begin
                        n_last_key = i_item.write_data;
                        if (i_item.write_data == KEY_START) begin
                            n_running = 1'b1;
                            restart   = 1'b1;
                        end else if (i_item.write_data == KEY_RELOAD && r_running) begin
                            restart = 1'b1;
                        end
                    end
                    REG_PRESC, REG_RELOAD: begin
                        if (!unlocked) begin
                            res.write_refused = 1'b1;
                        end else begin
                            if (i_item.reg_index == REG_PRESC) begin
                                n_presel = i_item.write_data[PreselW-1:0];
                            end else begin
                                n_reload = i_item.write_data[CountW-1:0];
                            end
                            restart = r_running;
                        end
                    end
                    REG_WINDOW: begin
                        if (!r_has_window || !unlocked) begin
                            res.write_refused = 1'b1;
                        end else begin
                            n_window = i_item.write_data[CountW-1:0];
                        end
                    end
                    default: res.write_refused = 1'b1;
                endcase
            end
            MODE_TICK: begin
                if (r_running) begin
                    if (r_down == '0) begin
                        res.reset_request = 1'b1;
                    end else if (precnt_inc >= prescale_div(r_presel)) begin
                        n_precnt = '0;
                        n_down   = down_dec;
                        if (down_dec == '0) begin
                            res.reset_request = 1'b1;
                        end
                    end else begin
                        n_precnt = precnt_inc[PrecntW-1:0];
                    end
                end
            end
            default: res = '0;
        endcase

        // restart takes the new reload value
        if (restart) begin
            n_down   = n_reload;
            n_precnt = '0;
        end

        // expiry: fall back to reset values
        if (res.reset_request) begin
            n_last_key = '0;
            n_presel   = '0;
            n_reload   = COUNT_MAX;
            n_window   = COUNT_MAX;
            n_running  = 1'b0;
            n_precnt   = '0;
            n_down     = '0;
        end
    end

    assign o_res = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_has_window <= 1'b1;
            r_last_key   <= '0;
            r_presel     <= '0;
            r_reload     <= COUNT_MAX;
            r_window     <= COUNT_MAX;
            r_running    <= 1'b0;
            r_precnt     <= '0;
            r_down       <= '0;
        end else begin
            if (i_cfg_we) begin
                r_has_window <= i_cfg_data;
            end
            if (i_step) begin
                r_last_key <= n_last_key;
                r_presel   <= n_presel;
                r_reload   <= n_reload;
                r_window   <= n_window;
                r_running  <= n_running;
                r_precnt   <= n_precnt;
                r_down     <= n_down;
            end
        end
    end

    a_stopped_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_running |-> (r_down == '0 && r_precnt == '0))
        else $error("stopped watchdog holds a nonzero count");

    a_expiry_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && res.reset_request) |=> (!r_running && r_last_key == '0))
        else $error("expiry did not return state to reset values");

    a_rq_on_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res.reset_request |-> (i_item.mode == MODE_TICK && r_running))
        else $error("reset request outside a running tick");

    a_refuse_on_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res.write_refused |-> (i_item.mode == MODE_WRITE))
        else $error("refusal flagged on a non-write item");

    a_refused_keeps_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && res.write_refused) |=> $stable(r_last_key))
        else $error("refused write changed the key");

endmodule

FILE: rtl/keyed_independent_watchdog_top.sv
// Channel   Dir  Payload                                      Transfer when
// i_in      in   mode, reg_index, write_data                  valid & ready
// o_res     out  read_data, reset_request, write_refused      valid & ready
// i_cfg     in   data (has_window_register)                   valid & ready
//
// One result per item, registered at the item's transfer and shown in the cycle after it.
// One item per cycle: state updates at the input transfer, result lands in
// the output register, and i_in.ready stays high while that register is
// empty or being drained; a stalled o_res holds i_in off after one item.
// i_cfg.ready is always high. Synchronous active-low reset, no clearing pass.
module keyed_independent_watchdog_top (
    input  logic  i_clk,
    input  logic  i_rst_n,
    kiwd_in_if.sink     i_in,
    kiwd_out_if.source  o_res,
    kiwd_cfg_if.sink    i_cfg
);
    import kiwd_pkg::*;

    logic      r_out_valid;
    t_out_item r_out;
    t_in_item  in_item;
    t_out_item core_res;
    logic      in_xfer;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = !r_out_valid || o_res.ready;
    assign in_xfer     = i_in.valid && i_in.ready;

    assign in_item.mode       = i_in.mode;
    assign in_item.reg_index  = i_in.reg_index;
    assign in_item.write_data = i_in.write_data;

    kiwd_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg.valid),
        .i_cfg_data (i_cfg.data),
        .i_step     (in_xfer),
        .i_item     (in_item),
        .o_res      (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_xfer) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // payload: load on transfer, hold otherwise
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_out <= core_res;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.read_data     = r_out.read_data;
    assign o_res.reset_request = r_out.reset_request;
    assign o_res.write_refused = r_out.write_refused;

endmodule

FILE: sim/keyed_independent_watchdog_top_tb.sv
module keyed_independent_watchdog_top_tb;

    import kiwd_pkg::*;

    localparam logic [1:0] MODE_NONE = 2'd3;
    localparam logic [2:0] REG_RSVD5 = 3'd5;
    localparam logic [2:0] REG_RSVD7 = 3'd7;

    localparam int PHASE_ITEMS = 450;
    localparam int HOLD_CYCLES = 300;
    localparam int LIMIT_CYCLES = 200000;

    typedef struct packed {
        t_in_item  stim;
        logic      known;
        t_out_item want;
    } t_dir_row;

    localparam t_out_item ZERO_RES = '0;
    localparam t_out_item REFUSED  = '{16'h0000, 1'b0, 1'b1};
    localparam t_out_item EXPIRED  = '{16'h0000, 1'b1, 1'b0};

    localparam int DIR_N = 28;
    localparam t_dir_row DIRECTED [DIR_N] = '{
        '{'{MODE_READ,  REG_PRESC,  16'h0000}, 1'b1, ZERO_RES},
        '{'{MODE_READ,  REG_RELOAD, 16'h0000}, 1'b1, '{16'h0FFF, 1'b0, 1'b0}},
        '{'{MODE_READ,  REG_WINDOW, 16'hFFFF}, 1'b1, '{16'h0FFF, 1'b0, 1'b0}},
        '{'{MODE_READ,  REG_STATUS, 16'hFFFF}, 1'b1, ZERO_RES},
        '{'{MODE_READ,  REG_RSVD7,  16'h0000}, 1'b1, ZERO_RES},
        '{'{MODE_WRITE, REG_PRESC,  16'h0007}, 1'b1, REFUSED},
        '{'{MODE_WRITE, REG_STATUS, 16'hFFFF}, 1'b1, REFUSED},
        '{'{MODE_WRITE, REG_RSVD5,  16'hFFFF}, 1'b1, REFUSED},
        '{'{MODE_WRITE, REG_KEY,    KEY_RELOAD}, 1'b1, ZERO_RES},
        '{'{MODE_TICK,  REG_KEY,    16'h0000}, 1'b1, ZERO_RES},
        '{'{MODE_NONE,  REG_RSVD7,  16'hFFFF}, 1'b1, ZERO_RES},
        '{'{MODE_WRITE, REG_KEY,    KEY_UNLOCK}, 1'b1, ZERO_RES},
        '{'{MODE_WRITE, REG_RELOAD, 16'hF000}, 1'b1, ZERO_RES},
        '{'{MODE_WRITE, REG_PRESC,  16'hFFFF}, 1'b1, ZERO_RES},
        '{'{MODE_READ,  REG_PRESC,  16'h0000}, 1'b1, '{16'h0007, 1'b0, 1'b0}},
        '{'{MODE_WRITE, REG_WINDOW, 16'h1234}, 1'b1, ZERO_RES},
        '{'{MODE_READ,  REG_WINDOW, 16'h0000}, 1'b1, '{16'h0234, 1'b0, 1'b0}},
        '{'{MODE_READ,  REG_KEY,    16'h0000}, 1'b1, ZERO_RES},
        '{'{MODE_WRITE, REG_KEY,    KEY_START}, 1'b1, ZERO_RES},
        '{'{MODE_TICK,  REG_KEY,    16'h0000}, 1'b1, EXPIRED},
        '{'{MODE_READ,  REG_RELOAD, 16'h0000}, 1'b1, '{16'h0FFF, 1'b0, 1'b0}},
        '{'{MODE_WRITE, REG_KEY,    KEY_UNLOCK}, 1'b0, ZERO_RES},
        '{'{MODE_WRITE, REG_RELOAD, 16'h0001}, 1'b0, ZERO_RES},
        '{'{MODE_WRITE, REG_KEY,    KEY_START}, 1'b0, ZERO_RES},
        '{'{MODE_TICK,  REG_KEY,    16'h0000}, 1'b0, ZERO_RES},
        '{'{MODE_TICK,  REG_KEY,    16'h0000}, 1'b0, ZERO_RES},
        '{'{MODE_TICK,  REG_KEY,    16'h0000}, 1'b0, ZERO_RES},
        '{'{MODE_TICK,  REG_KEY,    16'h0000}, 1'b0, ZERO_RES}
    };

    logic clk;
    logic rst_n;

    kiwd_in_if  in_if ();
    kiwd_out_if res_if ();
    kiwd_cfg_if cfg_if ();

    keyed_independent_watchdog_top u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .o_res   (res_if),
        .i_cfg   (cfg_if)
    );

    // watchdog state as the testbench sees it
    logic               m_has_window;
    logic [DataW-1:0]   m_last_key;
    logic [PreselW-1:0] m_presel;
    logic [CountW-1:0]  m_reload;
    logic [CountW-1:0]  m_window;
    logic               m_running;
    logic [PrecntW-1:0] m_precnt;
    logic [CountW-1:0]  m_down;

    t_out_item pending_res [$];
    t_in_item  stim_q [$];
    int        err_cnt;
    int        src_idle_pct;
    int        sink_stall_pct;
    logic      pressure_on;
    logic      hold_off;

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial begin
        #(20 * LIMIT_CYCLES);
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic flag_error(input string msg);
        $display("mismatch: %s", msg);
        err_cnt++;
    endtask

    function automatic void clear_watchdog();
        m_last_key = '0;
        m_presel   = '0;
        m_reload   = COUNT_MAX;
        m_window   = COUNT_MAX;
        m_running  = 1'b0;
        m_precnt   = '0;
        m_down     = '0;
    endfunction

    function automatic void restart_countdown();
        m_down   = m_reload;
        m_precnt = '0;
    endfunction

    function automatic t_out_item watchdog_next(input t_in_item it);
        t_out_item        r;
        logic             unlocked;
        logic [PrecntW:0] nxt;
        logic [PrecntW:0] div;
        r = '0;
        unlocked = (m_last_key == KEY_UNLOCK);
        case (it.mode)
            MODE_READ: begin
                case (it.reg_index)
                    REG_PRESC:  r.read_data = {13'd0, m_presel};
                    REG_RELOAD: r.read_data = {4'd0, m_reload};
                    REG_WINDOW: if (m_has_window) r.read_data = {4'd0, m_window};
                    default: ;
                endcase
            end
            MODE_WRITE: begin
                case (it.reg_index)
                    REG_KEY: begin
                        m_last_key = it.write_data;
                        if (it.write_data == KEY_START) begin
                            m_running = 1'b1;
                            restart_countdown();
                        end else if (it.write_data == KEY_RELOAD && m_running) begin
                            restart_countdown();
                        end
                    end
                    REG_PRESC, REG_RELOAD: begin
                        if (!unlocked) begin
                            r.write_refused = 1'b1;
                        end else begin
                            if (it.reg_index == REG_PRESC)
                                m_presel = it.write_data[PreselW-1:0];
                            else
                                m_reload = it.write_data[CountW-1:0];
                            if (m_running) restart_countdown();
                        end
                    end
                    REG_WINDOW: begin
                        if (!m_has_window || !unlocked)
                            r.write_refused = 1'b1;
                        else
                            m_window = it.write_data[CountW-1:0];
                    end
                    default: r.write_refused = 1'b1;
                endcase
            end
            MODE_TICK: begin
                if (m_running) begin
                    if (m_down == '0) begin
                        r.reset_request = 1'b1;
                    end else begin
                        nxt = {1'b0, m_precnt} + 9'd1;
                        div = (m_presel >= 3'd6) ? 9'd256 : (9'd4 << m_presel);
                        if (nxt >= div) begin
                            m_precnt = '0;
                            m_down   = m_down - 1'b1;
                            if (m_down == '0) r.reset_request = 1'b1;
                        end else begin
                            m_precnt = nxt[PrecntW-1:0];
                        end
                    end
                    if (r.reset_request) clear_watchdog();
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic t_in_item mk(input logic [1:0] m, input logic [2:0] idx,
                                    input logic [15:0] d);
        t_in_item r;
        r.mode       = m;
        r.reg_index  = idx;
        r.write_data = d;
        return r;
    endfunction

    function automatic t_in_item random_item();
        logic [15:0] d;
        case ($urandom_range(0, 7))
            0:       d = KEY_UNLOCK;
            1:       d = KEY_START;
            2:       d = KEY_RELOAD;
            default: d = 16'($urandom);
        endcase
        return mk(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)), d);
    endfunction

    // mostly unlock, program, start and tick; the rest is loose noise
    function automatic void queue_sequence();
        logic [15:0] d;
        int          n;
        if ($urandom_range(0, 99) < 70) begin
            stim_q.push_back(mk(MODE_WRITE, REG_KEY, KEY_UNLOCK));
            if ($urandom_range(0, 3) != 0) begin
                d = 16'($urandom);
                if ($urandom_range(0, 99) < 85) d[11:0] = 12'($urandom_range(0, 10));
                stim_q.push_back(mk(MODE_WRITE, REG_RELOAD, d));
            end
            if ($urandom_range(0, 3) != 0) begin
                d = 16'($urandom);
                if ($urandom_range(0, 99) < 80) d[2:0] = 3'($urandom_range(0, 2));
                stim_q.push_back(mk(MODE_WRITE, REG_PRESC, d));
            end
            if ($urandom_range(0, 3) == 0)
                stim_q.push_back(mk(MODE_WRITE, REG_WINDOW, 16'($urandom)));
            if ($urandom_range(0, 3) == 0)
                stim_q.push_back(mk(MODE_READ, 3'($urandom_range(0, 7)), 16'($urandom)));
            stim_q.push_back(mk(MODE_WRITE, REG_KEY, KEY_START));
            n = $urandom_range(1, 48);
            repeat (n) begin
                case ($urandom_range(0, 19))
                    0: stim_q.push_back(mk(MODE_READ, 3'($urandom_range(0, 7)),
                                           16'($urandom)));
                    1: stim_q.push_back(mk(MODE_WRITE, REG_KEY, KEY_RELOAD));
                    2: stim_q.push_back(random_item());
                    default: stim_q.push_back(mk(MODE_TICK, REG_KEY, 16'($urandom)));
                endcase
            end
        end else begin
            n = $urandom_range(1, 6);
            repeat (n) stim_q.push_back(random_item());
        end
    endfunction

    // valid stays high across back-to-back transfers; it drops only for a gap
    task automatic send_item(input t_in_item it, input logic known, input t_out_item want);
        t_out_item calc;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge clk);
        end
        in_if.valid      <= 1'b1;
        in_if.mode       <= it.mode;
        in_if.reg_index  <= it.reg_index;
        in_if.write_data <= it.write_data;
        do @(posedge clk); while (in_if.ready !== 1'b1);
        calc = watchdog_next(it);
        pending_res.push_back(known ? want : calc);
    endtask

    task automatic write_window_cfg(input logic v);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= v;
        do @(posedge clk); while (cfg_if.ready !== 1'b1);
        m_has_window = v;
        cfg_if.valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_res.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // result side: check every transfer, then pick next cycle's ready
    initial begin
        t_out_item want;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
                if (pending_res.size() == 0) begin
                    flag_error($sformatf("unexpected result rd=%h rq=%b wr=%b",
                        res_if.read_data, res_if.reset_request, res_if.write_refused));
                end else begin
                    want = pending_res.pop_front();
                    if (res_if.read_data !== want.read_data)
                        flag_error($sformatf("read_data got %h want %h",
                            res_if.read_data, want.read_data));
                    if (res_if.reset_request !== want.reset_request)
                        flag_error($sformatf("reset_request got %b want %b",
                            res_if.reset_request, want.reset_request));
                    if (res_if.write_refused !== want.write_refused)
                        flag_error($sformatf("write_refused got %b want %b",
                            res_if.write_refused, want.write_refused));
                end
            end
            if (hold_off)
                res_if.ready <= 1'b0;
            else
                res_if.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    // long result stall so the input side backs up
    initial begin
        hold_off <= 1'b0;
        wait (pressure_on === 1'b1);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    initial begin
        t_in_item it;
        int       n_items;
        in_if.valid      <= 1'b0;
        in_if.mode       <= MODE_READ;
        in_if.reg_index  <= REG_KEY;
        in_if.write_data <= '0;
        cfg_if.valid     <= 1'b0;
        cfg_if.data      <= 1'b0;
        rst_n            <= 1'b0;
        err_cnt        = 0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        pressure_on    = 1'b0;
        clear_watchdog();
        m_has_window = 1'b1;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_window_cfg(1'b1);
        for (int k = 0; k < DIR_N; k++)
            send_item(DIRECTED[k].stim, DIRECTED[k].known, DIRECTED[k].want);
        in_if.valid <= 1'b0;

        for (int ph = 0; ph < 4; ph++) begin
            wait_idle();
            write_window_cfg(ph % 2 == 1);
            case (ph)
                0: begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 0;
                    pressure_on    = 1'b1;
                end
                1: begin
                    src_idle_pct   = 46;
                    sink_stall_pct = 0;
                end
                2: begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 46;
                end
                default: begin
                    src_idle_pct   = 10;
                    sink_stall_pct = 10;
                end
            endcase
            n_items = 0;
            while (n_items < PHASE_ITEMS) begin
                queue_sequence();
                while (stim_q.size() != 0) begin
                    it = stim_q.pop_front();
                    if (it.mode != MODE_NONE) n_items++;
                    send_item(it, 1'b0, ZERO_RES);
                end
            end
            in_if.valid <= 1'b0;
        end

        while (pending_res.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (err_cnt == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
